// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is high.
`define SLT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("slt assertion failed");

// Clocked assertion that also holds across reset.
`define SLT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("slt assertion failed");

`endif

// File: rtl/slt_pkg.sv
`default_nettype none
package slt_pkg;

  localparam int ROW_WIDTH_DEF = 320;

  // pixel is dark when pixel*THR_DEN <= (max+min)*THR_NUM
  localparam int THR_NUM = 5;
  localparam int THR_DEN = 12;

  localparam int PIXEL_W  = 8;
  localparam int OFFSET_W = 12;
  localparam int DRIVE_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int BASE_W   = 8;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_STEER_GAIN   = 3'd0;
  localparam logic [2:0] REG_BASE_LEFT    = 3'd1;
  localparam logic [2:0] REG_BASE_RIGHT   = 3'd2;
  localparam logic [2:0] REG_SEARCH_LEFT  = 3'd3;
  localparam logic [2:0] REG_SEARCH_RIGHT = 3'd4;

  localparam logic [GAIN_W-1:0] STEER_GAIN_RST   = 16'd655;
  localparam logic [BASE_W-1:0] BASE_LEFT_RST    = 8'd51;
  localparam logic [BASE_W-1:0] BASE_RIGHT_RST   = 8'd45;
  localparam logic [BASE_W-1:0] SEARCH_LEFT_RST  = 8'd44;
  localparam logic [BASE_W-1:0] SEARCH_RIGHT_RST = 8'd51;

endpackage
`default_nettype wire

// File: rtl/scanline_line_tracker_top.sv
// Flow: after the row_end transfer the stored pixels are swept from the row memory, the
// dark-pixel offset sum is divided by the dark count in the bit-serial divider, then
// scaled by the gain and saturated before out_valid rises (no divide or multiply when no pixel is dark).
// Pixels are taken one a cycle while a row fills; in_ready stays low from row_end until
// the result is loaded into the output register. The row memory has a single read port.
// Synchronous active-high reset restores the control registers; no memory clearing pass.
`default_nettype none
module scanline_line_tracker_top #(
  parameter int ROW_WIDTH = slt_pkg::ROW_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel stream
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [slt_pkg::PIXEL_W-1:0]         pixel,
  input  logic                                row_end,
  // steering result
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                line_seen,
  output logic signed [slt_pkg::OFFSET_W-1:0] mean_offset,
  output logic [slt_pkg::DRIVE_W-1:0]         drive_left,
  output logic [slt_pkg::DRIVE_W-1:0]         drive_right,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [slt_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [slt_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [slt_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import slt_pkg::*;

  localparam int ADDR_W = $clog2(ROW_WIDTH);
  localparam int CNT_W  = $clog2(ROW_WIDTH + 1);
  localparam int OFS_W  = ADDR_W + 1;          // signed column offset
  localparam int SUM_W  = OFS_W + CNT_W;       // signed offset sum
  localparam int PROD_W = OFFSET_W + GAIN_W + 1;
  localparam int DV_W   = PROD_W - 8;
  localparam int ACC_W  = DV_W + 1;
  localparam logic signed [OFS_W-1:0] HALF = OFS_W'(ROW_WIDTH / 2);

  typedef enum logic [2:0] {S_FILL, S_SCAN, S_DIV, S_MUL, S_DONE} state_t;

  state_t state;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [GAIN_W-1:0] steer_gain;
  logic [BASE_W-1:0] base_left, base_right, search_left, search_right;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_gain   <= STEER_GAIN_RST;
      base_left    <= BASE_LEFT_RST;
      base_right   <= BASE_RIGHT_RST;
      search_left  <= SEARCH_LEFT_RST;
      search_right <= SEARCH_RIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_STEER_GAIN:   steer_gain   <= pwdata[GAIN_W-1:0];
        REG_BASE_LEFT:    base_left    <= pwdata[BASE_W-1:0];
        REG_BASE_RIGHT:   base_right   <= pwdata[BASE_W-1:0];
        REG_SEARCH_LEFT:  search_left  <= pwdata[BASE_W-1:0];
        REG_SEARCH_RIGHT: search_right <= pwdata[BASE_W-1:0];
        default: ;        // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_STEER_GAIN:   prdata = CFG_DATA_W'(steer_gain);
      REG_BASE_LEFT:    prdata = CFG_DATA_W'(base_left);
      REG_BASE_RIGHT:   prdata = CFG_DATA_W'(base_right);
      REG_SEARCH_LEFT:  prdata = CFG_DATA_W'(search_left);
      REG_SEARCH_RIGHT: prdata = CFG_DATA_W'(search_right);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Pixel capture: store each pixel and track the extremes
  // ---------------------------------------------------------------
  logic [CNT_W-1:0]   column_count;
  logic [PIXEL_W-1:0] brightest, darkest;
  logic               in_xfer, store;

  // hold off transfers while reset is high
  assign in_ready = (state == S_FILL) && !rst;
  assign in_xfer  = in_valid && in_ready;
  // ignore pixels beyond the row width (their row_end still ends the row)
  assign store    = in_xfer && (column_count < CNT_W'(ROW_WIDTH));

  // ---------------------------------------------------------------
  // Row sweep: read each stored pixel once and classify it
  // ---------------------------------------------------------------
  logic [CNT_W-1:0]         rd_idx;
  logic                     rd_pend;
  logic [ADDR_W-1:0]        rd_col;
  logic [PIXEL_W-1:0]       rd_data;
  logic                     issue, scan_finish, dark_px;
  logic [11:0]              limit;
  logic signed [OFS_W-1:0]  offset;
  logic signed [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]         dark_cnt;

  assign issue       = (state == S_SCAN) && (rd_idx < column_count);
  assign scan_finish = (state == S_SCAN) && !issue && !rd_pend;
  assign limit       = 12'(({4'd0, brightest} + {4'd0, darkest}) * 12'(THR_NUM));
  assign dark_px     = (12'(rd_data) * 12'(THR_DEN)) <= limit;
  assign offset      = $signed({1'b0, rd_col}) - HALF;

  slt_row_mem #(
    .DEPTH  (ROW_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_row_mem (
    .clk   (clk),
    .we    (store),
    .waddr (column_count[ADDR_W-1:0]),
    .wdata (pixel),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      brightest    <= '0;
      darkest      <= '1;
      rd_idx       <= '0;
      rd_pend      <= 1'b0;
    end else begin
      if (store) begin
        column_count <= column_count + 1'b1;
        if (pixel > brightest) brightest <= pixel;
        if (pixel < darkest)   darkest   <= pixel;
      end
      rd_pend <= issue;
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      // restart the row once the sweep has used the extremes
      if (scan_finish) begin
        column_count <= '0;
        brightest    <= '0;
        darkest      <= '1;
        rd_idx       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_col <= rd_idx[ADDR_W-1:0];
    end
    if (in_xfer && row_end) begin
      sum_acc  <= '0;
      dark_cnt <= '0;
    end else if (rd_pend && dark_px) begin
      sum_acc  <= sum_acc + SUM_W'(offset);
      dark_cnt <= dark_cnt + 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // Mean offset: magnitude division, sign applied after
  // ---------------------------------------------------------------
  logic             div_start, div_done, sum_neg;
  logic [SUM_W-1:0] div_dividend, div_quo;

  assign sum_neg      = sum_acc[SUM_W-1];
  assign div_dividend = sum_neg ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);
  assign div_start    = scan_finish && (dark_cnt != '0);

  slt_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dark_cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  logic signed [OFFSET_W-1:0] mean_q;
  logic signed [PROD_W-1:0]   prod;

  always_ff @(posedge clk) begin
    if (div_done) begin
      mean_q <= OFFSET_W'(sum_neg ? -$signed(div_quo) : $signed(div_quo));
    end
    if (state == S_MUL) begin
      prod <= mean_q * $signed({1'b0, steer_gain});
    end
  end

  // ---------------------------------------------------------------
  // Drive: base*256 + floor(prod/256), saturated to 16 bits
  // ---------------------------------------------------------------
  logic signed [DV_W-1:0] dv;

  assign dv = $signed(prod[PROD_W-1:8]);

  function automatic logic [DRIVE_W-1:0] sat_drive(input logic [BASE_W-1:0] base,
                                                   input logic signed [DV_W-1:0] d);
    logic signed [ACC_W-1:0] acc;
    acc = $signed(ACC_W'({base, 8'd0})) + ACC_W'(d);
    if (acc < 0) begin
      sat_drive = '0;
    end else if (acc > $signed(ACC_W'(17'hFFFF))) begin
      sat_drive = '1;
    end else begin
      sat_drive = acc[DRIVE_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------
  logic res_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      out_valid <= 1'b0;
      res_seen  <= 1'b0;
    end else begin
      // drop the result once transferred, unless a new one loads this cycle
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          if (in_xfer && row_end) state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_finish) begin
            res_seen <= (dark_cnt != '0);
            state    <= (dark_cnt != '0) ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_MUL;
        end
        S_MUL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            line_seen <= res_seen;
            if (res_seen) begin
              mean_offset <= mean_q;
              drive_left  <= sat_drive(base_left, dv);
              drive_right <= sat_drive(base_right, dv);
            end else begin
              mean_offset <= '0;
              drive_left  <= {search_left, 8'd0};
              drive_right <= {search_right, 8'd0};
            end
            state <= S_FILL;
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/slt_row_mem.sv
`default_nettype none
module slt_row_mem #(
  parameter int DEPTH  = slt_pkg::ROW_WIDTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [slt_pkg::PIXEL_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [slt_pkg::PIXEL_W-1:0] rdata
);
  import slt_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/slt_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle.
module slt_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVS_W:0]   rem;
  logic [DVS_W-1:0] dvs;
  logic [STEP_W-1:0] step;
  logic             run;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] trial;

  assign rem_sh = {rem[DVS_W-1:0], quotient[DVD_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= STEP_W'(DVD_W);
      end else if (run) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (run) begin
      if (!trial[DVS_W+1]) begin
        rem      <= trial[DVS_W:0];
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/slt_checker.sv
`default_nettype none
`include "assert_macros.svh"
module slt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        row_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic        line_seen,
  input logic [11:0] mean_offset,
  input logic [15:0] drive_left,
  input logic [15:0] drive_right
);

  // a stalled result holds
  `SLT_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable({line_seen, mean_offset, drive_left, drive_right}))

  // no line: zero offset and whole-unit search drives
  `SLT_ASSERT(a_absent_shape, clk, rst, out_valid && !line_seen |-> mean_offset == 12'd0 && drive_left[7:0] == 8'd0 && drive_right[7:0] == 8'd0)

  // the row is evaluated before more pixels are taken
  `SLT_ASSERT(a_row_end_stall, clk, rst, in_valid && in_ready && row_end |=> !in_ready)

  // reset empties the output register
  `SLT_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid)

endmodule

bind scanline_line_tracker_top slt_checker u_slt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .row_end     (row_end),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .line_seen   (line_seen),
  .mean_offset (mean_offset),
  .drive_left  (drive_left),
  .drive_right (drive_right)
);
`default_nettype wire
